[hdl/tga_pkg.sv]
// Shared types, codes and reset values of the TGA run-length pixel decoder.
package tga_pkg;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_COMPRESSED_MODE = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT   = 2'd1;
    localparam logic [1:0] REG_TOTAL_PIXELS    = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ST_CLIPPED     = 2'd2;

    // Packet header split point and the run offset.
    localparam logic [7:0] RUN_FLAG   = 8'd128;
    localparam logic [7:0] RUN_OFFSET = 8'd127;

    // Register reset values.
    localparam logic        RST_COMPRESSED_MODE = 1'b1;
    localparam logic [2:0]  RST_CHANNEL_COUNT   = 3'd4;
    localparam logic [31:0] RST_TOTAL_PIXELS    = 32'd1;

    // Configuration as seen by the decode logic.
    typedef struct packed {
        logic        compressed_mode;
        logic [2:0]  channel_count;
        logic [31:0] total_pixels;
    } t_cfg;

    // One result beat.
    typedef struct packed {
        logic [31:0] pixel_color;
        logic [7:0]  repeat_count;
        logic        image_done;
        logic [1:0]  status;
    } t_result;

endpackage

[hdl/tga_byte_if.sv]
// Input channel: one stream byte per beat.
interface tga_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

[hdl/tga_pix_if.sv]
// Output channel: one decoded colour with its repeat count per beat.
interface tga_pix_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_color;
    logic [7:0]  repeat_count;
    logic        image_done;
    logic [1:0]  status;

    modport source (output valid, output pixel_color, output repeat_count,
                    output image_done, output status, input ready);
    modport sink   (input valid, input pixel_color, input repeat_count,
                    input image_done, input status, output ready);
endinterface

[hdl/tga_rle_pixel_decoder_unit.sv]
// Top level of the TGA run-length pixel decoder.
//
// Usage: feed the pixel-data bytes of a Targa image, one byte per beat, on
// i_byte. Each completed colour leaves on o_pix as one beat with its colour,
// repeat count, an image_done flag when the configured pixel total is reached,
// and a status (ok, unsupported format, run clipped at image end). Header
// bytes and partial colours give no beat. The APB port sets compressed mode,
// channel count and total pixels; write it only while the block is idle.
//
// An accepted byte sits in the input register while the decode logic works
// on it; its result lands in the output register and is offered there until
// o_pix.ready takes it. One byte is accepted every cycle while o_pix is taken;
// the decoder state updates once per byte, which sets that rate.
//
// Reset clears both pipeline registers and returns the decoder to waiting
// for a packet header. When the receiver stalls, the output register holds
// its beat and the input register holds one more byte; i_byte.ready then
// drops until o_pix.ready returns.
module tga_rle_pixel_decoder_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tga_byte_if.sink      i_byte,
    tga_pix_if.source     o_pix,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import tga_pkg::*;

    t_cfg       cfg;
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_out_vld;
    t_result    r_out;
    logic       adv;
    logic       core_emit;
    t_result    core_result;

    tga_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The held byte moves on when the output register is free or drains.
    assign adv          = r_in_vld && (!r_out_vld || o_pix.ready);
    assign i_byte.ready = !r_in_vld || adv;

    tga_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (adv),
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .o_emit   (core_emit),
        .o_result (core_result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && core_emit) begin
            r_out_vld <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && core_emit) begin
            r_out <= core_result;
        end
    end

    assign o_pix.valid        = r_out_vld;
    assign o_pix.pixel_color  = r_out.pixel_color;
    assign o_pix.repeat_count = r_out.repeat_count;
    assign o_pix.image_done   = r_out.image_done;
    assign o_pix.status       = r_out.status;

endmodule

[hdl/tga_cfg.sv]
// APB register file holding the decoder configuration.
module tga_cfg (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    output tga_pkg::t_cfg o_cfg
);
    import tga_pkg::*;

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // Register writes land in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.compressed_mode <= RST_COMPRESSED_MODE;
            r_cfg.channel_count   <= RST_CHANNEL_COUNT;
            r_cfg.total_pixels    <= RST_TOTAL_PIXELS;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_COMPRESSED_MODE: r_cfg.compressed_mode <= pwdata[0];
                REG_CHANNEL_COUNT:   r_cfg.channel_count   <= pwdata[2:0];
                REG_TOTAL_PIXELS:    r_cfg.total_pixels    <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (paddr[3:2])
            REG_COMPRESSED_MODE: prdata = {31'd0, r_cfg.compressed_mode};
            REG_CHANNEL_COUNT:   prdata = {29'd0, r_cfg.channel_count};
            REG_TOTAL_PIXELS:    prdata = r_cfg.total_pixels;
            default:             prdata = 32'd0;
        endcase
    end

endmodule

[hdl/tga_core.sv]
// Packet parser, channel gatherer and pixel counter: one byte per cycle while i_fire is high.
module tga_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    input  tga_pkg::t_cfg     i_cfg,
    output logic              o_emit,
    output tga_pkg::t_result  o_result
);
    import tga_pkg::*;

    logic        r_awaiting_header, n_awaiting_header;
    logic        r_run_packet,      n_run_packet;
    logic [7:0]  r_packet_remaining, n_packet_remaining;
    logic [31:0] r_color_gather,    n_color_gather;
    logic [1:0]  r_channel_index,   n_channel_index;
    logic [31:0] r_pixels_done,     n_pixels_done;

    // Next state and result for the byte in the input register.
    always_comb begin
        logic [2:0]  eff_ch;
        logic        complete;
        logic [7:0]  count;
        logic [31:0] total;
        logic [31:0] room;
        logic [31:0] cnt_ext;
        logic        do_emit;

        n_awaiting_header  = r_awaiting_header;
        n_run_packet       = r_run_packet;
        n_packet_remaining = r_packet_remaining;
        n_color_gather     = r_color_gather;
        n_channel_index    = r_channel_index;
        n_pixels_done      = r_pixels_done;
        o_emit             = 1'b0;
        o_result           = '0;
        do_emit            = 1'b0;
        count              = 8'd1;

        eff_ch = (i_cfg.channel_count <= 3'd3) ? 3'd3 : 3'd4;

        // Channel byte gathering, first byte lowest.
        if (r_channel_index == 2'd0) begin
            n_color_gather = {24'd0, i_byte};
        end else begin
            n_color_gather = r_color_gather
                           | ({24'd0, i_byte} << {r_channel_index, 3'b000});
        end
        complete = ({1'b0, r_channel_index} + 3'd1) >= eff_ch;

        if (!i_cfg.compressed_mode) begin
            if (eff_ch == 3'd3) begin
                // Uncompressed 24-bit is not supported: flag, keep state.
                n_color_gather  = r_color_gather;
                o_emit          = 1'b1;
                o_result.status = ST_UNSUPPORTED;
            end else begin
                n_channel_index = complete ? 2'd0 : r_channel_index + 2'd1;
                do_emit         = complete;
            end
        end else if (r_awaiting_header) begin
            // Packet header: raw below the run flag, run otherwise.
            n_color_gather    = r_color_gather;
            n_awaiting_header = 1'b0;
            n_channel_index   = 2'd0;
            if (i_byte < RUN_FLAG) begin
                n_run_packet       = 1'b0;
                n_packet_remaining = i_byte + 8'd1;
            end else begin
                n_run_packet       = 1'b1;
                n_packet_remaining = i_byte - RUN_OFFSET;
            end
        end else begin
            n_channel_index = complete ? 2'd0 : r_channel_index + 2'd1;
            if (complete) begin
                do_emit = 1'b1;
                if (r_run_packet) begin
                    count              = r_packet_remaining;
                    n_packet_remaining = 8'd0;
                end else begin
                    n_packet_remaining = r_packet_remaining - 8'd1;
                end
                if (count == 8'd0) begin
                    count = 8'd1;
                end
                if (n_packet_remaining == 8'd0) begin
                    n_awaiting_header = 1'b1;
                end
            end
        end

        // Count pixels against the image total, clipping an overshoot.
        total   = (i_cfg.total_pixels == 32'd0) ? 32'd1 : i_cfg.total_pixels;
        room    = (r_pixels_done < total) ? total - r_pixels_done : 32'd1;
        cnt_ext = {24'd0, count};
        if (do_emit) begin
            o_emit                = 1'b1;
            o_result.pixel_color  = n_color_gather;
            o_result.repeat_count = count;
            o_result.status       = ST_OK;
            if (cnt_ext > room) begin
                o_result.repeat_count = room[7:0];
                o_result.status       = ST_CLIPPED;
            end
            if (cnt_ext >= room) begin
                o_result.image_done = 1'b1;
                n_pixels_done       = 32'd0;
                n_awaiting_header   = 1'b1;
                n_run_packet        = 1'b0;
                n_packet_remaining  = 8'd0;
                n_channel_index     = 2'd0;
            end else begin
                n_pixels_done = r_pixels_done + cnt_ext;
            end
        end
    end

    // Decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting_header  <= 1'b1;
            r_run_packet       <= 1'b0;
            r_packet_remaining <= 8'd0;
            r_color_gather     <= 32'd0;
            r_channel_index    <= 2'd0;
            r_pixels_done      <= 32'd0;
        end else if (i_fire) begin
            r_awaiting_header  <= n_awaiting_header;
            r_run_packet       <= n_run_packet;
            r_packet_remaining <= n_packet_remaining;
            r_color_gather     <= n_color_gather;
            r_channel_index    <= n_channel_index;
            r_pixels_done      <= n_pixels_done;
        end
    end

endmodule

[tb/testbench.sv]
// Self-checking testbench for the TGA run-length pixel decoder.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tga_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int GAP_MAX       = 19;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PRINT_LIMIT   = 50;
    localparam int NUM_ROWS      = 29;

    // One row of the directed table: a register write or a stream byte.
    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        logic [7:0]  data;
        logic        typed;
        t_result     want;
    } t_dir_row;

    localparam t_result NO_BEAT = '0;

    // Directed stimulus. Rows with a typed result are checked against that result;
    // all others are checked against the predictor.
    localparam t_dir_row DIRECTED_ROWS [NUM_ROWS] = '{
        // Shortest run packet at reset settings: one 4-channel colour ends the image.
        '{ROW_BYTE, '0, '0, 8'h80, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'h11, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'h22, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'h33, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'h44, 1'b1, '{32'h4433_2211, 8'd1, 1'b1, ST_OK}},
        // Longest run packet overshoots a ten-pixel image and gets clipped.
        '{ROW_CFG, REG_TOTAL_PIXELS, 32'd10, '0, 1'b0, NO_BEAT},
        '{ROW_CFG, REG_CHANNEL_COUNT, 32'd3, '0, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'h00, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'hA5, 1'b1, '{32'h00A5_00FF, 8'd10, 1'b1, ST_CLIPPED}},
        // Shortest and longest raw packets; the long one is left open.
        '{ROW_BYTE, '0, '0, 8'h00, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'h01, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'h02, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'h03, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'h7F, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'h10, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'h20, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'h30, 1'b0, NO_BEAT},
        // Uncompressed 24-bit data is unsupported, also for a channel count below 3.
        '{ROW_CFG, REG_COMPRESSED_MODE, 32'd0, '0, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'h00, 1'b1, '{32'd0, 8'd0, 1'b0, ST_UNSUPPORTED}},
        '{ROW_CFG, REG_CHANNEL_COUNT, 32'd0, '0, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'hFF, 1'b1, '{32'd0, 8'd0, 1'b0, ST_UNSUPPORTED}},
        // Channel count above 4 and a zero total, with the pixel count already past it.
        '{ROW_CFG, REG_CHANNEL_COUNT, 32'd7, '0, 1'b0, NO_BEAT},
        '{ROW_CFG, REG_TOTAL_PIXELS, 32'd0, '0, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'h01, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'h02, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'h04, 1'b0, NO_BEAT},
        '{ROW_BYTE, '0, '0, 8'h08, 1'b0, NO_BEAT}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tga_byte_if byte_ch ();
    tga_pix_if  pix_ch ();

    tga_rle_pixel_decoder_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_pix   (pix_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor copy of the configuration and the decode state.
    logic        cfg_compressed;
    logic [2:0]  cfg_channels;
    logic [31:0] cfg_total;
    logic        await_hdr;
    logic        in_run;
    logic [7:0]  pkt_left;
    logic [31:0] color_acc;
    logic [1:0]  chan_idx;
    logic [31:0] pix_done;

    t_result     expected_pixels [$];

    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned beats_seen = 0;
    int unsigned images_done = 0;
    int unsigned runs_clipped = 0;
    int unsigned unsupported_beats = 0;
    int unsigned settings_used = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic flag_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // Adds one channel byte to the colour; returns 1 when the colour is complete.
    function automatic bit add_channel_byte(input logic [7:0] b);
        int unsigned idx;
        int unsigned width;
        idx = chan_idx;
        width = (cfg_channels <= 3'd3) ? 3 : 4;
        if (idx == 0) begin
            color_acc = {24'd0, b};
        end else begin
            color_acc = color_acc | ({24'd0, b} << (8 * idx));
        end
        if (idx + 1 >= width) begin
            chan_idx = 2'd0;
            return 1'b1;
        end
        chan_idx = 2'(idx + 1);
        return 1'b0;
    endfunction

    // Builds the beat for a completed colour, clipping the count at the image end.
    function automatic t_result close_color(input int unsigned count);
        logic [32:0] total;
        logic [32:0] room;
        logic [32:0] n;
        t_result     beat;
        total = (cfg_total == 32'd0) ? 33'd1 : {1'b0, cfg_total};
        room = ({1'b0, pix_done} < total) ? total - {1'b0, pix_done} : 33'd1;
        n = 33'(count);
        beat = '0;
        beat.status = ST_OK;
        if (n > room) begin
            n = room;
            beat.status = ST_CLIPPED;
        end
        if (n >= room) begin
            beat.image_done = 1'b1;
            pix_done = 32'd0;
            await_hdr = 1'b1;
            in_run = 1'b0;
            pkt_left = 8'd0;
            chan_idx = 2'd0;
        end else begin
            pix_done = pix_done + n[31:0];
        end
        beat.pixel_color = color_acc;
        beat.repeat_count = n[7:0];
        return beat;
    endfunction

    // Predicts the decoder's response to one stream byte.
    function automatic bit decode_byte(input logic [7:0] b, output t_result beat);
        int unsigned count;
        beat = '0;
        if (!cfg_compressed) begin
            if (cfg_channels <= 3'd3) begin
                beat.status = ST_UNSUPPORTED;
                return 1'b1;
            end
            if (!add_channel_byte(b)) return 1'b0;
            beat = close_color(1);
            return 1'b1;
        end
        // Packet header: opens a raw or a run packet, gives no beat.
        if (await_hdr) begin
            in_run = (b >= RUN_FLAG);
            pkt_left = in_run ? b - RUN_OFFSET : b + 8'd1;
            await_hdr = 1'b0;
            chan_idx = 2'd0;
            return 1'b0;
        end
        if (!add_channel_byte(b)) return 1'b0;
        if (in_run) begin
            count = pkt_left;
            pkt_left = 8'd0;
        end else begin
            count = 1;
            pkt_left = pkt_left - 8'd1;
        end
        if (count == 0) count = 1;
        if (pkt_left == 8'd0) await_hdr = 1'b1;
        beat = close_color(count);
        return 1'b1;
    endfunction

    // Waits for the decoder to drain, writes one register and reads it back.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] stored;
        byte_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_COMPRESSED_MODE: begin
                cfg_compressed = value[0];
                stored = {31'd0, value[0]};
            end
            REG_CHANNEL_COUNT: begin
                cfg_channels = value[2:0];
                stored = {29'd0, value[2:0]};
            end
            REG_TOTAL_PIXELS: begin
                cfg_total = value;
                stored = value;
            end
            default: begin
                stored = '0;
            end
        endcase
        // Read-back access.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== stored) begin
            flag_mismatch($sformatf("register %0d reads %h, wrote %h", idx, prdata, stored));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offers one byte, after a random gap unless tx_steady is set, and records what it should produce.
    task automatic send_byte(input logic [7:0] b, input bit use_typed, input t_result typed);
        int unsigned gap;
        t_result     beat;
        bit          has;
        gap = tx_steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        has = decode_byte(b, beat);
        if (use_typed) begin
            expected_pixels.push_back(typed);
        end else if (has) begin
            expected_pixels.push_back(beat);
        end
        bytes_sent++;
    endtask

    // Result side: random stalls per beat unless rx_steady is set, each beat compared with the oldest expectation.
    initial begin
        int unsigned stall;
        t_result     got;
        t_result     want;
        pix_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, GAP_MAX);
            if (stall != 0) begin
                pix_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pix_ch.ready <= 1'b1;
            do @(posedge i_clk); while (pix_ch.valid !== 1'b1);
            got.pixel_color  = pix_ch.pixel_color;
            got.repeat_count = pix_ch.repeat_count;
            got.image_done   = pix_ch.image_done;
            got.status       = pix_ch.status;
            beats_seen++;
            if (expected_pixels.size() == 0) begin
                flag_mismatch($sformatf("beat with nothing expected: %h", got));
            end else begin
                want = expected_pixels.pop_front();
                if (got.pixel_color !== want.pixel_color) begin
                    flag_mismatch($sformatf("pixel_color %h, expected %h",
                                            got.pixel_color, want.pixel_color));
                end
                if (got.repeat_count !== want.repeat_count) begin
                    flag_mismatch($sformatf("repeat_count %0d, expected %0d",
                                            got.repeat_count, want.repeat_count));
                end
                if (got.image_done !== want.image_done) begin
                    flag_mismatch($sformatf("image_done %b, expected %b",
                                            got.image_done, want.image_done));
                end
                if (got.status !== want.status) begin
                    flag_mismatch($sformatf("status %0d, expected %0d",
                                            got.status, want.status));
                end
                if (want.image_done) images_done++;
                if (want.status == ST_CLIPPED) runs_clipped++;
                if (want.status == ST_UNSUPPORTED) unsupported_beats++;
            end
        end
    end

    // Stop a hung run.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("ERROR: run hit the cycle limit of %0d", CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Reset, directed table, random phases, drain and verdict.
    initial begin
        t_dir_row    row;
        int unsigned first_random;
        int unsigned phase_end;
        logic [7:0]  b;
        logic        comp;
        logic [2:0]  chans;
        logic [31:0] total;

        cfg_compressed = RST_COMPRESSED_MODE;
        cfg_channels   = RST_CHANNEL_COUNT;
        cfg_total      = RST_TOTAL_PIXELS;
        await_hdr      = 1'b1;
        in_run         = 1'b0;
        pkt_left       = 8'd0;
        color_acc      = 32'd0;
        chan_idx       = 2'd0;
        pix_done       = 32'd0;

        i_rst_n           <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= 8'd0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        settings_used = 1;
        for (int i = 0; i < NUM_ROWS; i++) begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_CFG) begin
                write_reg(row.reg_idx, row.value);
            end else begin
                send_byte(row.data, row.typed, row.want);
            end
        end

        // Random phases: new settings each phase, the stream state carried across.
        first_random = bytes_sent;
        while (bytes_sent < first_random + RANDOM_ITEMS) begin
            comp = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 7))
                0:       chans = 3'($urandom_range(0, 7));
                1, 2, 3: chans = 3'd3;
                default: chans = 3'd4;
            endcase
            case ($urandom_range(0, 11))
                0:       total = 32'd0;
                1:       total = 32'd1;
                2:       total = 32'hFFFF_FFFF;
                3:       total = 32'd4294836225;
                4, 5:    total = $urandom_range(100, 1000);
                default: total = $urandom_range(1, 48);
            endcase
            write_reg(REG_COMPRESSED_MODE, {31'd0, comp});
            write_reg(REG_CHANNEL_COUNT, {29'd0, chans});
            write_reg(REG_TOTAL_PIXELS, total);
            settings_used++;
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);

            // Unsupported format answers every byte the same way, so keep it short.
            if (!comp && chans <= 3'd3) begin
                phase_end = bytes_sent + $urandom_range(4, 16);
            end else begin
                phase_end = bytes_sent + $urandom_range(20, 120);
            end
            while (bytes_sent < phase_end) begin
                if (cfg_compressed && await_hdr && $urandom_range(0, 9) != 0) begin
                    case ($urandom_range(0, 3))
                        0:       b = 8'($urandom_range(0, 7));
                        1:       b = 8'($urandom_range(0, 127));
                        2:       b = 8'($urandom_range(128, 143));
                        default: b = 8'($urandom_range(128, 255));
                    endcase
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
                send_byte(b, 1'b0, NO_BEAT);
            end
        end

        byte_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d stream bytes under %0d register settings, %0d beats checked.",
                 bytes_sent, settings_used, beats_seen);
        $display("Beats included %0d image ends, %0d clipped runs, %0d unsupported-format.",
                 images_done, runs_clipped, unsupported_beats);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
